### rtl/fpalu_pkg.sv
package fpalu_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int DW            = 32 + FRACTION_BITS;
    localparam int SQ_STEPS      = 26;
    localparam int SQ_SHIFT      = 10;
    localparam logic [31:0] SQ_TOP = 32'h4000_0000;
    localparam logic [31:0] ONE    = 32'd1 << FRACTION_BITS;
    localparam logic [31:0] FMASK  = ONE - 32'd1;

    localparam logic [3:0] MODE_ADD      = 4'd0;
    localparam logic [3:0] MODE_SUB      = 4'd1;
    localparam logic [3:0] MODE_MUL      = 4'd2;
    localparam logic [3:0] MODE_DIV      = 4'd3;
    localparam logic [3:0] MODE_NEG      = 4'd4;
    localparam logic [3:0] MODE_FLOOR    = 4'd5;
    localparam logic [3:0] MODE_CEIL     = 4'd6;
    localparam logic [3:0] MODE_SQRT     = 4'd7;
    localparam logic [3:0] MODE_FROM_INT = 4'd8;
    localparam logic [3:0] MODE_FRACTION = 4'd9;
    localparam logic [3:0] MODE_CMP      = 4'd10;

    typedef enum logic [1:0] {
        OP_SIMPLE,
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_t;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } req_t;

    typedef struct packed {
        logic signed [31:0] result;
        logic               less_than;
        logic               equal;
        logic               div_by_zero;
        logic               negative_root;
    } rsp_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] res;
        logic        lt;
        logic        eq;
    } entry_t;

    typedef struct packed {
        op_t           op;
        logic [31:0]   res;
        logic          lt;
        logic          eq;
        logic          dz;
        logic          nr;
        logic          qneg;
        logic [32:0]   rem;
        logic [DW-1:0] num;
        logic [31:0]   dmag;
        logic [31:0]   sr;
        logic [31:0]   sq;
    } stage_t;

endpackage

### rtl/fpalu_front.sv
module fpalu_front (
    input  fpalu_pkg::req_t   req,
    output fpalu_pkg::entry_t entry
);
    import fpalu_pkg::*;

    logic [31:0] a;
    logic [31:0] b;

    assign a = req.operand_a;
    assign b = req.operand_b;

    always_comb
    begin
        entry.op  = OP_SIMPLE;
        entry.a   = a;
        entry.b   = b;
        entry.res = 32'd0;
        entry.lt  = 1'b0;
        entry.eq  = 1'b0;
        case (req.mode) inside
            MODE_ADD:      entry.res = a + b;
            MODE_SUB:      entry.res = a - b;
            MODE_MUL:      entry.op  = OP_MUL;
            MODE_DIV, MODE_FRACTION: entry.op = OP_DIV;
            MODE_NEG:      entry.res = 32'd0 - a;
            MODE_FLOOR:    entry.res = a & ~FMASK;
            MODE_CEIL:
            begin
                if ((a & FMASK) == 32'd0)
                    entry.res = a;
                else
                    entry.res = (a & ~FMASK) + ONE;
            end
            MODE_SQRT:     entry.op  = OP_SQRT;
            MODE_FROM_INT: entry.res = a << FRACTION_BITS;
            MODE_CMP:
            begin
                entry.lt = req.operand_a < req.operand_b;
                entry.eq = a == b;
            end
            default:       entry.res = 32'd0;
        endcase
    end
endmodule

### rtl/fpalu_queue.sv
module fpalu_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fpalu_pkg::entry_t push_data,
    output logic              full,
    output logic              pop_valid,
    output fpalu_pkg::entry_t pop_data
);
    import fpalu_pkg::*;

    entry_t     mem_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full      = count_reg == 2'd2;
    assign pop_valid = count_reg != 2'd0;
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop_valid;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop_valid};
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("push into full queue");
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop_valid) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count lost a push");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers out of step");
`endif
endmodule

### rtl/fpalu_back.sv
module fpalu_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  fpalu_pkg::entry_t in_entry,
    output logic              done,
    output fpalu_pkg::rsp_t   rsp
);
    import fpalu_pkg::*;

    stage_t             stg_reg [0:DW];
    logic               vld_reg [0:DW];
    stage_t             stg0_next;
    logic signed [63:0] prod_reg;
    logic               done_reg;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;
    logic [31:0]        amag;

    always_comb
    begin
        amag           = in_entry.a[31] ? (32'd0 - in_entry.a) : in_entry.a;
        stg0_next.op   = in_entry.op;
        stg0_next.res  = in_entry.res;
        stg0_next.lt   = in_entry.lt;
        stg0_next.eq   = in_entry.eq;
        stg0_next.dz   = (in_entry.op == OP_DIV) && (in_entry.b == 32'd0);
        stg0_next.nr   = (in_entry.op == OP_SQRT) && in_entry.a[31];
        stg0_next.qneg = in_entry.a[31] ^ in_entry.b[31];
        stg0_next.rem  = 33'd0;
        stg0_next.num  = {amag, {FRACTION_BITS{1'b0}}};
        stg0_next.dmag = in_entry.b[31] ? (32'd0 - in_entry.b) : in_entry.b;
        stg0_next.sr   = in_entry.a;
        stg0_next.sq   = 32'd0;
    end

    always_ff @(posedge clk)
    begin
        stg_reg[0] <= stg0_next;
        prod_reg   <= $signed(in_entry.a) * $signed(in_entry.b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= in_valid;
    end

    for (genvar k = 1; k <= DW; k++)
    begin : g_stage
        stage_t             s_next;
        logic [32:0]        trial;
        logic [31:0]        sbit;
        logic [31:0]        t;
        logic signed [63:0] shifted;

        always_comb
        begin
            s_next  = stg_reg[k-1];
            trial   = {stg_reg[k-1].rem[31:0], stg_reg[k-1].num[DW-1]};
            sbit    = SQ_TOP >> (k - 1);
            t       = stg_reg[k-1].sq + sbit;
            shifted = prod_reg >>> FRACTION_BITS;
            if (trial >= {1'b0, stg_reg[k-1].dmag})
            begin
                s_next.rem = trial - {1'b0, stg_reg[k-1].dmag};
                s_next.num = {stg_reg[k-1].num[DW-2:0], 1'b1};
            end
            else
            begin
                s_next.rem = trial;
                s_next.num = {stg_reg[k-1].num[DW-2:0], 1'b0};
            end
            if (k <= SQ_STEPS)
            begin
                if (stg_reg[k-1].sr >= t)
                begin
                    s_next.sr = (stg_reg[k-1].sr - t) << 1;
                    s_next.sq = t + sbit;
                end
                else
                begin
                    s_next.sr = stg_reg[k-1].sr << 1;
                end
            end
            if (k == 1 && stg_reg[k-1].op == OP_MUL)
                s_next.res = shifted[31:0];
        end

        always_ff @(posedge clk)
        begin
            stg_reg[k] <= s_next;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    always_comb
    begin
        rsp_next.result        = stg_reg[DW].res;
        rsp_next.less_than     = stg_reg[DW].lt;
        rsp_next.equal         = stg_reg[DW].eq;
        rsp_next.div_by_zero   = stg_reg[DW].dz;
        rsp_next.negative_root = stg_reg[DW].nr;
        case (stg_reg[DW].op)
            OP_DIV:
            begin
                if (stg_reg[DW].dz)
                    rsp_next.result = 32'd0;
                else if (stg_reg[DW].qneg)
                    rsp_next.result = 32'd0 - stg_reg[DW].num[31:0];
                else
                    rsp_next.result = stg_reg[DW].num[31:0];
            end
            OP_SQRT:
            begin
                if (stg_reg[DW].nr)
                    rsp_next.result = '1;
                else
                    rsp_next.result = stg_reg[DW].sq >> SQ_SHIFT;
            end
            default: rsp_next.result = stg_reg[DW].res;
        endcase
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[DW];
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> ##(DW+2) done_reg)
        else $error("request lost in pipeline");
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.div_by_zero) |-> rsp_reg.result == 32'd0)
        else $error("zero divisor gave nonzero result");
    a_nr_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && rsp_reg.negative_root) |-> rsp_reg.result == '1)
        else $error("negative root result wrong");
    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(rsp_reg.div_by_zero && rsp_reg.negative_root))
        else $error("conflicting flags");
`endif
endmodule

### rtl/fixed_point_alu.sv
// Throughput: one request per cycle; busy stays low in steady operation.
// The latency is set by the restoring divider, one quotient bit per stage over
// 32 + FRACTION_BITS stages; all modes walk the same pipeline to keep order.
// Reset clears the queue and all valid bits; the receiver cannot stall.
module fixed_point_alu (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  fpalu_pkg::req_t req,
    output logic            done,
    output fpalu_pkg::rsp_t rsp
);
    import fpalu_pkg::*;

    entry_t entry;
    entry_t pop_data;
    logic   full;
    logic   pop_valid;
    logic   push;

    assign busy = full;
    assign push = start && !full;

    fpalu_front u_front (
        .req   (req),
        .entry (entry)
    );

    fpalu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .full      (full),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    fpalu_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pop_valid),
        .in_entry (pop_data),
        .done     (done),
        .rsp      (rsp)
    );
endmodule

### test/fixed_point_alu_test.sv
module fixed_point_alu_test;
    import fpalu_pkg::*;

    localparam int LATENCY     = 35 + FRACTION_BITS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_REQS = 700;
    localparam logic [3:0] MODE_SPARE    = 4'd13;
    localparam logic [3:0] MODE_SPARE_LO = 4'd11;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic done;
    req_t req = '0;
    rsp_t rsp;

    rsp_t expected_rsps[$];
    int   mismatches = 0;
    int   cycles = 0;

    typedef struct {
        req_t r;
        bit   typed;
        rsp_t want;
    } vector_t;

    fixed_point_alu dut (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .req  (req),
        .done (done),
        .rsp  (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] fixed_sqrt(logic [31:0] x);
        logic [31:0] r;
        logic [31:0] bit_w;
        logic [31:0] q;
        logic [31:0] t;
        r = x;
        bit_w = 32'h4000_0000;
        q = 0;
        while (bit_w > 32'h10)
        begin
            t = q + bit_w;
            if (r >= t)
            begin
                r = r - t;
                q = t + bit_w;
            end
            r = r << 1;
            bit_w = bit_w >> 1;
        end
        return q >> 10;
    endfunction

    function automatic rsp_t alu_result(req_t r);
        rsp_t o;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] w;
        logic [31:0] one;
        logic [31:0] fmask;
        o = '0;
        a = r.operand_a;
        b = r.operand_b;
        one = 32'd1 << FRACTION_BITS;
        fmask = one - 32'd1;
        case (r.mode)
            MODE_ADD: o.result = r.operand_a + r.operand_b;
            MODE_SUB: o.result = r.operand_a - r.operand_b;
            MODE_MUL:
            begin
                w = (a * b) >>> FRACTION_BITS;
                o.result = w[31:0];
            end
            MODE_DIV, MODE_FRACTION:
            begin
                if (b == 0)
                    o.div_by_zero = 1'b1;
                else
                begin
                    w = (a <<< FRACTION_BITS) / b;
                    o.result = w[31:0];
                end
            end
            MODE_NEG: o.result = -r.operand_a;
            MODE_FLOOR: o.result = r.operand_a & ~fmask;
            MODE_CEIL:
                if ((r.operand_a & fmask) == 0)
                    o.result = r.operand_a;
                else
                    o.result = (r.operand_a & ~fmask) + one;
            MODE_SQRT:
                if (r.operand_a < 0)
                begin
                    o.result = '1;
                    o.negative_root = 1'b1;
                end
                else
                    o.result = fixed_sqrt(r.operand_a);
            MODE_FROM_INT: o.result = r.operand_a << FRACTION_BITS;
            MODE_CMP:
            begin
                o.less_than = r.operand_a < r.operand_b;
                o.equal = r.operand_a == r.operand_b;
            end
            default: o = '0;
        endcase
        return o;
    endfunction

    function automatic rsp_t flags_rsp(logic [31:0] res, logic lt, logic eq, logic dz,
                                       logic nr);
        rsp_t o;
        o.result = res;
        o.less_than = lt;
        o.equal = eq;
        o.div_by_zero = dz;
        o.negative_root = nr;
        return o;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
        begin
            if (expected_rsps.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected result %h", rsp);
                mismatches <= mismatches + 1;
            end
            else
            begin
                if (rsp !== expected_rsps[0])
                begin
                    if (mismatches < 10)
                        $display("mismatch: expected %h actual %h", expected_rsps[0], rsp);
                    mismatches <= mismatches + 1;
                end
                void'(expected_rsps.pop_front());
            end
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_request(req_t r, bit typed, rsp_t want);
        req <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_rsps.push_back(typed ? want : alu_result(r));
        @(negedge clk);
    endtask

    task automatic maybe_idle(bit allow);
        if (allow && $urandom_range(0, 5) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    endtask

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 3) << FRACTION_BITS;
            3: return $urandom_range(0, 2) - 1;
            4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        vector_t vectors[$];
        req_t r;
        vectors.push_back('{'{MODE_ADD, 32'sh7fff_ffff, 32'sd1}, 1,
                            flags_rsp(32'h8000_0000, 0, 0, 0, 0)});
        vectors.push_back('{'{MODE_SUB, 32'sh8000_0000, 32'sd1}, 1,
                            flags_rsp(32'h7fff_ffff, 0, 0, 0, 0)});
        vectors.push_back('{'{MODE_MUL, 32'sh8000_0000, 32'sh8000_0000}, 0, '0});
        vectors.push_back('{'{MODE_MUL, 32'sh7fff_ffff, -32'sd1}, 0, '0});
        vectors.push_back('{'{MODE_DIV, 32'sh1234_5678, 32'sd0}, 1,
                            flags_rsp(0, 0, 0, 1, 0)});
        vectors.push_back('{'{MODE_DIV, 32'sh8000_0000, -32'sd1}, 0, '0});
        vectors.push_back('{'{MODE_DIV, -32'sd7, 32'sd3}, 0, '0});
        vectors.push_back('{'{MODE_NEG, 32'sh8000_0000, 32'sd0}, 1,
                            flags_rsp(32'h8000_0000, 0, 0, 0, 0)});
        vectors.push_back('{'{MODE_FLOOR, -32'sd1, 32'sd0}, 1,
                            flags_rsp(32'hffff_0000, 0, 0, 0, 0)});
        vectors.push_back('{'{MODE_CEIL, 32'sh0003_0000, 32'sd0}, 1,
                            flags_rsp(32'h0003_0000, 0, 0, 0, 0)});
        vectors.push_back('{'{MODE_CEIL, 32'sh7fff_ffff, 32'sd0}, 1,
                            flags_rsp(32'h8000_0000, 0, 0, 0, 0)});
        vectors.push_back('{'{MODE_SQRT, -32'sd1, 32'sd0}, 1,
                            flags_rsp(32'hffff_ffff, 0, 0, 0, 1)});
        vectors.push_back('{'{MODE_SQRT, 32'sh7fff_ffff, 32'sd0}, 0, '0});
        vectors.push_back('{'{MODE_SQRT, 32'sd0, 32'sd0}, 0, '0});
        vectors.push_back('{'{MODE_SQRT, 32'sh0004_0000, 32'sd0}, 0, '0});
        vectors.push_back('{'{MODE_FROM_INT, 32'sh8000_ffff, 32'sd0}, 1,
                            flags_rsp(32'hffff_0000, 0, 0, 0, 0)});
        vectors.push_back('{'{MODE_FRACTION, 32'sd1, 32'sd0}, 1,
                            flags_rsp(0, 0, 0, 1, 0)});
        vectors.push_back('{'{MODE_FRACTION, 32'sh8000_0000, 32'sd3}, 0, '0});
        vectors.push_back('{'{MODE_CMP, 32'sh8000_0000, 32'sh7fff_ffff}, 1,
                            flags_rsp(0, 1, 0, 0, 0)});
        vectors.push_back('{'{MODE_CMP, 32'sd5, 32'sd5}, 1, flags_rsp(0, 0, 1, 0, 0)});
        vectors.push_back('{'{MODE_CMP, 32'sd6, 32'sd5}, 1, flags_rsp(0, 0, 0, 0, 0)});
        vectors.push_back('{'{MODE_SPARE, -32'sd1, -32'sd1}, 1, '0});
        vectors.push_back('{'{MODE_SPARE_HI, -32'sd1, -32'sd1}, 1, '0});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (vectors[i])
            send_request(vectors[i].r, vectors[i].typed, vectors[i].want);
        start <= 1'b0;
        // hold until the pipeline drains
        while (expected_rsps.size() != 0)
            @(negedge clk);

        for (int n = 0; n < RANDOM_REQS; n++)
        begin
            maybe_idle(n < RANDOM_REQS - 100);
            r.mode = ($urandom_range(0, 20) == 0)
                     ? 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI))
                     : 4'($urandom_range(MODE_ADD, MODE_CMP));
            r.operand_a = rand_operand();
            r.operand_b = ($urandom_range(0, 7) == 0) ? r.operand_a : rand_operand();
            if ($urandom_range(0, 15) == 0)
                r.operand_b = 0;
            send_request(r, 0, '0);
        end
        start <= 1'b0;

        while (expected_rsps.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 10) @(negedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
